FILE: design/lcgr_pkg.sv
`default_nettype none
package lcgr_pkg;

	localparam int unsigned NUM_LANES_DEF = 8;
	localparam int unsigned MAX_PAIRS_DEF = 64;

	localparam int unsigned CFG_W = 32;
	localparam int unsigned SEED_W = 16;
	localparam logic [SEED_W-1:0] SEED_MULT = 16'd3125;
	localparam logic [SEED_W-1:0] SEED_BASE = 16'd3634;
	localparam logic signed [31:0] TWO_LN2_Q30 = 32'sd1488522236;

	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_UNI_LOW = 2'd0;
	localparam cfg_idx_t CFG_UNI_HIGH = 2'd1;
	localparam cfg_idx_t CFG_NRM_MEAN = 2'd2;
	localparam cfg_idx_t CFG_NRM_SPREAD = 2'd3;

	typedef logic [1:0] status_t;
	localparam status_t STAT_OK = 2'd0;
	localparam status_t STAT_BAD_LANE = 2'd1;
	localparam status_t STAT_SAT = 2'd2;
	localparam status_t STAT_GAVE_UP = 2'd3;

	typedef struct packed {
		status_t status;
		logic [31:0] sample;
	} result_t;

	// round product (Q.32 scaled) to Q16.16, add offset, flag overflow as STAT_SAT with a zero sample
	function automatic result_t fin_round(input logic signed [64:0] p,
			input logic signed [31:0] off);
		logic signed [65:0] v;
		result_t r;
		v = ($signed({p[64], p}) + 66'sd32768) >>> 16;
		v = v + $signed({{34{off[31]}}, off});
		if ((&v[65:31]) || ~(|v[65:31])) begin
			r.status = STAT_OK;
			r.sample = v[31:0];
		end else begin
			r.status = STAT_SAT;
			r.sample = '0;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: design/lcgr_mul.sv
`default_nettype none
module lcgr_mul (
	input  wire logic                clk,
	input  wire logic signed [32:0]  op_a,
	input  wire logic signed [31:0]  op_b,
	output logic signed [64:0]       prod_q
);
	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
	end
endmodule
`default_nettype wire

FILE: design/lcgr_seeds.sv
`default_nettype none
module lcgr_seeds #(
	parameter int unsigned NUM_LANES = lcgr_pkg::NUM_LANES_DEF,
	parameter int unsigned LW = (NUM_LANES > 1) ? $clog2(NUM_LANES) : 1
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [LW-1:0]                idx,
	input  wire logic                         advance,
	output logic [lcgr_pkg::SEED_W-1:0]       seed
);
	import lcgr_pkg::*;

	logic [SEED_W-1:0] seeds_q [NUM_LANES];
	logic [SEED_W-1:0] next_seed;

	assign seed = seeds_q[idx];
	// seed * 3125 mod 2^16
	assign next_seed = seed * SEED_MULT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LANES; i++) begin
				seeds_q[i] <= SEED_BASE + SEED_W'(i);
			end
		end else if (advance) begin
			seeds_q[idx] <= next_seed;
		end
	end
endmodule
`default_nettype wire

FILE: design/lcg_uniform_and_polar_normal_rng.sv
`default_nettype none
// Channel | Signals                                   | Direction
// in      | in_valid, in_ready, kind, lane, last_in_batch | request
// out     | out_valid, out_ready, sample, status, last    | result
// cfg     | cfg_we, cfg_index, cfg_data                   | register write
//
// One item at a time through a sequencer around a shared 33x32 multiplier.
// Uniform item: draw, multiply, finish. Normal item: draw a pair, square and
// sum, redrawing each rejected pair; then normalize, log2 (one bit per
// squaring through the multiplier), scale and load divider, divide (one bit
// per cycle), square root (one digit per cycle), then scale, round and write
// back. Give-up item: after MAX_PAIRS rejected pairs.
// Reset clears control and loads each lane seed with 3634 plus its index.
// A finished result waits in the output register; the next item is taken
// meanwhile and only the write-back waits on out_ready.
module lcg_uniform_and_polar_normal_rng #(
	parameter int unsigned NUM_LANES = lcgr_pkg::NUM_LANES_DEF,
	parameter int unsigned MAX_PAIRS = lcgr_pkg::MAX_PAIRS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic                kind,
	input  wire logic [3:0]          lane,
	input  wire logic                last_in_batch,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic signed [31:0]       sample,
	output lcgr_pkg::status_t        status,
	output logic                     last,
	input  wire logic                cfg_we,
	input  wire lcgr_pkg::cfg_idx_t  cfg_index,
	input  wire logic [31:0]         cfg_data
);
	import lcgr_pkg::*;

	localparam int unsigned LW = (NUM_LANES > 1) ? $clog2(NUM_LANES) : 1;
	localparam int unsigned PW = $clog2(MAX_PAIRS + 1);

	typedef enum logic [20:0] {
		ST_IDLE   = 21'd1 << 0,
		ST_UDRAW  = 21'd1 << 1,
		ST_UMUL   = 21'd1 << 2,
		ST_UFIN   = 21'd1 << 3,
		ST_NDRAWA = 21'd1 << 4,
		ST_NDRAWB = 21'd1 << 5,
		ST_NSQA   = 21'd1 << 6,
		ST_NSQB   = 21'd1 << 7,
		ST_NSUM   = 21'd1 << 8,
		ST_NNORM  = 21'd1 << 9,
		ST_NLOGM  = 21'd1 << 10,
		ST_NLOGB  = 21'd1 << 11,
		ST_NKL    = 21'd1 << 12,
		ST_NKLR   = 21'd1 << 13,
		ST_NTMUL  = 21'd1 << 14,
		ST_DINIT  = 21'd1 << 15,
		ST_NDIV   = 21'd1 << 16,
		ST_NSQRT  = 21'd1 << 17,
		ST_NZMUL  = 21'd1 << 18,
		ST_NZFIN  = 21'd1 << 19,
		ST_DONE   = 21'd1 << 20
	} state_t;

	state_t state_q;

	// configuration
	logic signed [31:0] low_q, high_q, mean_q, spread_q;

	// request
	logic last_in_q;
	logic [3:0] lane_q;
	logic [PW-1:0] pairs_q;

	// working registers
	logic signed [16:0] a_q, b_q;
	logic [30:0] a2_q, s_q, m_q;
	logic [4:0] e_q, it_q;
	logic [23:0] frac_q;
	logic [29:0] kl_q;
	logic [31:0] rem_q;
	logic [30:0] nq_q;
	logic [39:0] xs_q;
	logic [19:0] rt_q;
	logic [23:0] rr_q;
	result_t res_q;

	// shared multiplier
	logic signed [32:0] op_a;
	logic signed [31:0] op_b;
	logic signed [64:0] prod_q;

	lcgr_mul u_mul (
		.clk    (clk),
		.op_a   (op_a),
		.op_b   (op_b),
		.prod_q (prod_q)
	);

	// lane seeds
	logic seed_adv;
	logic [SEED_W-1:0] seed;

	lcgr_seeds #(.NUM_LANES(NUM_LANES), .LW(LW)) u_seeds (
		.clk     (clk),
		.arst_n  (arst_n),
		.idx     (lane_q[LW-1:0]),
		.advance (seed_adv),
		.seed    (seed)
	);

	assign seed_adv = (state_q == ST_UDRAW) || (state_q == ST_NDRAWA) ||
			(state_q == ST_NDRAWB);

	// combinational helpers
	logic signed [16:0] draw_c;
	logic [31:0] sum_c;
	logic [28:0] l_c;
	logic [4:0] nk_c;
	logic [31:0] sq_c;
	logic [31:0] dt_c;
	logic [23:0] cur_c, trial_c;
	logic [20:0] mag_c;
	logic signed [21:0] z_c;
	logic [59:0] klr_c;

	assign draw_c = $signed({1'b0, seed}) - 17'sd32768;
	assign sum_c = {1'b0, a2_q} + {1'b0, prod_q[30:0]};
	assign l_c = 29'(30 << 24) - {e_q, frac_q};
	assign nk_c = 5'd16 >> it_q[2:0];
	assign sq_c = prod_q[61:30];
	assign dt_c = {rem_q[30:0], nq_q[30]};
	assign cur_c = {rr_q[21:0], xs_q[39:38]};
	assign trial_c = {2'b00, rt_q, 2'b01};
	assign mag_c = {1'b0, rt_q} + 21'(rr_q > {4'b0, rt_q});
	assign z_c = a_q[16] ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
	assign klr_c = prod_q[59:0] + 60'd536870912;

	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (state_q)
			ST_UMUL: begin
				op_a = $signed({high_q[31], high_q}) - $signed({low_q[31], low_q});
				op_b = $signed({16'b0, seed});
			end
			ST_NSQA: begin
				op_a = 33'(a_q);
				op_b = 32'(a_q);
			end
			ST_NSQB: begin
				op_a = 33'(b_q);
				op_b = 32'(b_q);
			end
			ST_NLOGM: begin
				op_a = $signed({2'b0, m_q});
				op_b = $signed({1'b0, m_q});
			end
			ST_NKL: begin
				op_a = $signed({4'b0, l_c});
				op_b = TWO_LN2_Q30;
			end
			ST_NTMUL: begin
				op_a = $signed({2'b0, a2_q});
				op_b = $signed({2'b0, kl_q});
			end
			ST_NZMUL: begin
				op_a = 33'(z_c);
				op_b = spread_q;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign in_ready = (state_q == ST_IDLE);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q <= 32'sd0;
			high_q <= 32'sd65536;
			mean_q <= 32'sd0;
			spread_q <= 32'sd65536;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_UNI_LOW:    low_q <= cfg_data;
				CFG_UNI_HIGH:   high_q <= cfg_data;
				CFG_NRM_MEAN:   mean_q <= cfg_data;
				CFG_NRM_SPREAD: spread_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid <= 1'b0;
			pairs_q <= '0;
			it_q <= '0;
		end else begin
			// write-back in ST_DONE keeps out_valid set
			if (out_valid && out_ready && (state_q != ST_DONE)) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						lane_q <= lane;
						last_in_q <= last_in_batch;
						pairs_q <= '0;
						if ({1'b0, lane} >= 5'(NUM_LANES)) begin
							res_q.status <= STAT_BAD_LANE;
							res_q.sample <= '0;
							state_q <= ST_DONE;
						end else if (kind) begin
							state_q <= ST_NDRAWA;
						end else begin
							state_q <= ST_UDRAW;
						end
					end
				end
				ST_UDRAW: state_q <= ST_UMUL;
				ST_UMUL:  state_q <= ST_UFIN;
				ST_UFIN: begin
					res_q <= fin_round(prod_q, low_q);
					state_q <= ST_DONE;
				end
				ST_NDRAWA: state_q <= ST_NDRAWB;
				ST_NDRAWB: begin
					a_q <= draw_c;
					state_q <= ST_NSQA;
				end
				ST_NSQA: begin
					b_q <= draw_c;
					state_q <= ST_NSQB;
				end
				ST_NSQB: begin
					a2_q <= prod_q[30:0];
					state_q <= ST_NSUM;
				end
				ST_NSUM: begin
					// reject when s > 2^30 or s == 0
					if (sum_c > 32'd1073741824 || sum_c == 32'd0) begin
						if (pairs_q == PW'(MAX_PAIRS - 1)) begin
							res_q.status <= STAT_GAVE_UP;
							res_q.sample <= '0;
							state_q <= ST_DONE;
						end else begin
							pairs_q <= pairs_q + 1'b1;
							state_q <= ST_NDRAWA;
						end
					end else begin
						s_q <= sum_c[30:0];
						m_q <= sum_c[30:0];
						e_q <= 5'd30;
						it_q <= '0;
						state_q <= ST_NNORM;
					end
				end
				ST_NNORM: begin
					// binary search for the leading one: 16, 8, 4, 2, 1
					if ((m_q >> (5'd31 - nk_c)) == 31'd0) begin
						m_q <= m_q << nk_c;
						e_q <= e_q - nk_c;
					end
					if (it_q == 5'd4) begin
						it_q <= '0;
						frac_q <= '0;
						state_q <= ST_NLOGM;
					end else begin
						it_q <= it_q + 1'b1;
					end
				end
				ST_NLOGM: state_q <= ST_NLOGB;
				ST_NLOGB: begin
					if (sq_c[31]) begin
						m_q <= sq_c[31:1];
					end else begin
						m_q <= sq_c[30:0];
					end
					frac_q <= {frac_q[22:0], sq_c[31]};
					if (it_q == 5'd23) begin
						it_q <= '0;
						state_q <= ST_NKL;
					end else begin
						it_q <= it_q + 1'b1;
						state_q <= ST_NLOGM;
					end
				end
				ST_NKL: state_q <= ST_NKLR;
				ST_NKLR: begin
					kl_q <= klr_c[59:30];
					state_q <= ST_NTMUL;
				end
				ST_NTMUL: state_q <= ST_DINIT;
				ST_DINIT: begin
					// quotient fits 31 bits, so the top bits seed the remainder
					rem_q <= {2'b0, prod_q[60:31]};
					nq_q <= prod_q[30:0];
					it_q <= '0;
					state_q <= ST_NDIV;
				end
				ST_NDIV: begin
					if (dt_c >= {1'b0, s_q}) begin
						rem_q <= dt_c - {1'b0, s_q};
						nq_q <= {nq_q[29:0], 1'b1};
					end else begin
						rem_q <= dt_c;
						nq_q <= {nq_q[29:0], 1'b0};
					end
					if (it_q == 5'd30) begin
						// radicand T << 8, padded to an even bit count
						xs_q <= {1'b0, nq_q[29:0], (dt_c >= {1'b0, s_q}), 8'b0};
						rt_q <= '0;
						rr_q <= '0;
						it_q <= '0;
						state_q <= ST_NSQRT;
					end else begin
						it_q <= it_q + 1'b1;
					end
				end
				ST_NSQRT: begin
					// digit-by-digit: twenty digits, one per cycle
					if (cur_c >= trial_c) begin
						rr_q <= cur_c - trial_c;
						rt_q <= {rt_q[18:0], 1'b1};
					end else begin
						rr_q <= cur_c;
						rt_q <= {rt_q[18:0], 1'b0};
					end
					xs_q <= xs_q << 2;
					if (it_q == 5'd19) begin
						it_q <= '0;
						state_q <= ST_NZMUL;
					end else begin
						it_q <= it_q + 1'b1;
					end
				end
				ST_NZMUL: state_q <= ST_NZFIN;
				ST_NZFIN: begin
					res_q <= fin_round(prod_q, mean_q);
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						sample <= res_q.sample;
						status <= res_q.status;
						last <= last_in_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: design/lcgr_checker.sv
`default_nettype none
module lcgr_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic signed [31:0] sample,
	input wire lcgr_pkg::status_t status,
	input wire logic              last
);
	import lcgr_pkg::*;

	// a held result does not change
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample) &&
		$stable(status) && $stable(last))
		else $error("result changed while stalled");

	// any error status carries a zero sample
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STAT_OK |-> sample == 32'sd0)
		else $error("nonzero sample with error status");

	// one item at a time: ready drops after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("accepted while busy");

	// an accept with an empty output does not raise out_valid at once
	a_min_lat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> !out_valid)
		else $error("result too early");

endmodule

bind lcg_uniform_and_polar_normal_rng lcgr_checker u_lcgr_checker (.*);
`default_nettype wire
